### sv/spba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spba_pkg
// Shared types and constants for the swap page bitmap allocator.
// ----------------------------------------------------------------------------
package spba_pkg;

   localparam int PAGE_W     = 16;
   localparam int SLOT_W     = 10;   // slot index of a page number
   localparam int BIT_W      = 6;    // page within a slot
   localparam int LINK_W     = 11;   // free-list link / slot count
   localparam int WORD_W     = 64;   // occupancy word
   localparam int PAGE_LIMIT_SLOTS = 1024;

   localparam logic [LINK_W-1:0] SLOTS_RESET = 11'd1024;

   typedef enum logic [1:0] {
      STAT_OK          = 2'd0,
      STAT_NO_FREE     = 2'd1,
      STAT_NOT_ALLOC   = 2'd2,
      STAT_OUT_OF_RANGE = 2'd3
   } status_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic issue;      // request word taken, launch memory read
      logic commit;     // apply update and load result register
      logic cfg_write;  // slot count written, reinitialize
   } dp_cmd_type;

   // lowest clear bit; 63 when bits 0..62 are all set
   function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
      logic [BIT_W-1:0] r;
      r = BIT_W'(WORD_W - 1);
      for (int i = WORD_W - 2; i >= 0; i--) begin
         if (!w[i]) r = BIT_W'(i);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### sv/spba_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spba_ctrl
// Two-state sequencer: take a csr write or accept a request, then commit the
// request once the result register is free.
// ----------------------------------------------------------------------------
module spba_ctrl
   import spba_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   input  wire        csr_valid,
   output logic       csr_ready,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // result register can take a new word this cycle
   assign out_free = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !csr_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // a pending csr write goes first; the request is stalled while it is taken
   always_comb begin
      req_stall     = 1'b1;
      csr_ready     = 1'b0;
      cmd.issue     = 1'b0;
      cmd.commit    = 1'b0;
      cmd.cfg_write = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = csr_valid;
            csr_ready     = 1'b1;
            cmd.issue     = req_valid && !csr_valid;
            cmd.cfg_write = csr_valid;
         end
         ST_EXEC: begin
            cmd.commit = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit)        rsp_valid_in = 1'b1;
      else if (!rsp_stall)   rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed word not presented");

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && rsp_valid_ff && rsp_stall) |=> state_ff == ST_EXEC)
      else $error("left execute while result register full");

   a_issue_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |=> state_ff == ST_EXEC)
      else $error("accepted request word not executed");

endmodule
`default_nettype wire

### sv/spba_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spba_datapath
// Occupancy and link memories, free-list head, fill mark and result register.
// Slots at or above the fill mark read as never touched: word zero, link
// slot+1. The first allocate in such a slot writes both memories.
// ----------------------------------------------------------------------------
module spba_datapath
   import spba_pkg::*;
#(
   parameter int NUM_SLOTS = 1024
) (
   input  wire                clock,
   input  wire                reset,
   input  wire dp_cmd_type    cmd,
   input  wire                req_command,
   input  wire [PAGE_W-1:0]   req_page_number,
   input  wire [LINK_W-1:0]   csr_slots_in_use,
   output logic [1:0]         rsp_status,
   output logic [PAGE_W-1:0]  rsp_granted_page
);

   localparam int MEM_DEPTH = (NUM_SLOTS < PAGE_LIMIT_SLOTS) ? NUM_SLOTS : PAGE_LIMIT_SLOTS;
   localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam logic [LINK_W-1:0] MAX_SLOTS = LINK_W'(MEM_DEPTH);

   logic [WORD_W-1:0] occ_mem  [MEM_DEPTH];
   logic [LINK_W-1:0] link_mem [MEM_DEPTH];

   logic [LINK_W-1:0] slots_ff, head_ff, head_in, mark_ff, mark_in;
   logic              cmd_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [BIT_W-1:0]  bit_ff;
   status_type        err_ff;
   logic [WORD_W-1:0] occ_rd_ff;
   logic [LINK_W-1:0] link_rd_ff;
   logic [1:0]        status_ff;
   logic [PAGE_W-1:0] granted_ff;

   logic [LINK_W-1:0] count;
   logic [SLOT_W-1:0] slot_sel;
   status_type        err_sel;
   logic [AW-1:0]     rd_addr, wr_addr;

   logic              fresh;
   logic [WORD_W-1:0] occ_cur, occ_wr, mask;
   logic [LINK_W-1:0] link_cur, link_wr, slot_next;
   logic [BIT_W-1:0]  alloc_bit;
   logic              occ_we, link_we;
   status_type        status_sel;
   logic [PAGE_W-1:0] granted_sel;

   assign count = (slots_ff > MAX_SLOTS) ? MAX_SLOTS : slots_ff;

   // ---- issue: pick slot and screen range ----
   always_comb begin
      if (req_command == CMD_ALLOC) begin
         slot_sel = head_ff[SLOT_W-1:0];
         err_sel  = (head_ff >= count) ? STAT_NO_FREE : STAT_OK;
      end else begin
         slot_sel = req_page_number[PAGE_W-1:BIT_W];
         err_sel  = ({1'b0, req_page_number[PAGE_W-1:BIT_W]} >= count) ?
                    STAT_OUT_OF_RANGE : STAT_OK;
      end
   end

   assign rd_addr = slot_sel[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         cmd_ff     <= req_command;
         slot_ff    <= slot_sel;
         bit_ff     <= req_page_number[BIT_W-1:0];
         err_ff     <= err_sel;
         occ_rd_ff  <= occ_mem[rd_addr];
         link_rd_ff <= link_mem[rd_addr];
      end
   end

   // ---- commit: read-modify-write ----
   assign slot_next = {1'b0, slot_ff} + LINK_W'(1);
   assign fresh     = {1'b0, slot_ff} >= mark_ff;
   assign occ_cur   = fresh ? '0 : occ_rd_ff;
   assign link_cur  = fresh ? slot_next : link_rd_ff;
   assign alloc_bit = first_zero(occ_cur);
   assign mask      = WORD_W'(1) << ((cmd_ff == CMD_ALLOC) ? alloc_bit : bit_ff);
   assign wr_addr   = slot_ff[AW-1:0];

   always_comb begin
      status_sel  = err_ff;
      granted_sel = '0;
      occ_we      = 1'b0;
      link_we     = 1'b0;
      occ_wr      = occ_cur;
      link_wr     = link_cur;
      head_in     = head_ff;
      mark_in     = mark_ff;
      if (err_ff == STAT_OK) begin
         if (cmd_ff == CMD_ALLOC) begin
            occ_wr      = occ_cur | mask;
            occ_we      = 1'b1;
            link_we     = 1'b1;      // seeds the link on first touch
            granted_sel = {slot_ff, alloc_bit};
            if (fresh) mark_in = slot_next;
            if (&occ_wr) head_in = link_cur;
         end else if ((occ_cur & mask) == '0) begin
            status_sel = STAT_NOT_ALLOC;
         end else begin
            occ_wr = occ_cur & ~mask;
            occ_we = 1'b1;
            if (&occ_cur) begin
               link_wr = head_ff;
               link_we = 1'b1;
               head_in = {1'b0, slot_ff};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && occ_we)  occ_mem[wr_addr]  <= occ_wr;
      if (cmd.commit && link_we) link_mem[wr_addr] <= link_wr;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff  <= status_sel;
         granted_ff <= granted_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= SLOTS_RESET;
         head_ff  <= '0;
         mark_ff  <= '0;
      end else if (cmd.cfg_write) begin
         slots_ff <= csr_slots_in_use;
         head_ff  <= '0;
         mark_ff  <= '0;
      end else if (cmd.commit) begin
         head_ff  <= head_in;
         mark_ff  <= mark_in;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_granted_page = granted_ff;

   a_mark_bound: assert property (@(posedge clock) disable iff (reset)
      mark_ff <= MAX_SLOTS)
      else $error("fill mark beyond memory depth");

   a_fresh_at_mark: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && err_ff == STAT_OK && cmd_ff == CMD_ALLOC && fresh)
      |-> {1'b0, slot_ff} == mark_ff)
      else $error("allocate skipped an untouched slot");

   a_grant_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && status_sel == STAT_OK && cmd_ff == CMD_ALLOC)
      |=> {1'b0, rsp_granted_page[PAGE_W-1:BIT_W]} < count)
      else $error("granted page outside the file");

endmodule
`default_nettype wire

### sv/swap_page_bitmap_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swap_page_bitmap_allocator_core
// Bitmap page allocator for one swap file: 64-page slots with a linked
// free list of slots that still have a clear page.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  req_    | in        | valid / stall      | command, page_number
//  rsp_    | out       | valid / stall      | status, granted_page
//  csr_    | in        | valid / ready      | slots_in_use
//
//  Each request is accepted in the idle state, which reads the slot's occupancy
//  word and link; the execute state writes them back and loads the result
//  register. The single-port read-modify-write sets the rate.
//  Reset and a csr write reinitialize at once through a fill mark; no sweep.
//  A stalled result holds the commit cycle; the request side stalls meanwhile.
// ----------------------------------------------------------------------------
module swap_page_bitmap_allocator_core
   import spba_pkg::*;
#(
   parameter int NUM_SLOTS = 1024
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire                req_command,
   input  wire [PAGE_W-1:0]   req_page_number,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [PAGE_W-1:0]  rsp_granted_page,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire [LINK_W-1:0]   csr_slots_in_use
);

   dp_cmd_type cmd;

   spba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   spba_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_command      (req_command),
      .req_page_number  (req_page_number),
      .csr_slots_in_use (csr_slots_in_use),
      .rsp_status       (rsp_status),
      .rsp_granted_page (rsp_granted_page)
   );

endmodule
`default_nettype wire

### bench/tb_swap_page_bitmap_allocator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_swap_page_bitmap_allocator_core
// Self-checking bench for the swap page allocator. A scoreboard class keeps
// its own copy of the occupancy words, slot links and list head, predicts
// the status and granted page of every accepted request word, and checks
// the result words in order. The run steps through several slot counts
// (empty, one slot, full size, clamped) and four idle/stall mixes.
// ----------------------------------------------------------------------------

class page_alloc_scoreboard;
   localparam int DUT_SLOTS = 1024;

   logic [63:0]                   occupancy [DUT_SLOTS];
   logic [spba_pkg::LINK_W-1:0]   slot_link [DUT_SLOTS];
   logic [spba_pkg::LINK_W-1:0]   list_head;
   logic [spba_pkg::LINK_W-1:0]   file_slots;
   spba_pkg::status_type          want_status [$];
   logic [spba_pkg::PAGE_W-1:0]   want_page [$];
   int                            errors;

   function new();
      errors = 0;
      file_slots = spba_pkg::SLOTS_RESET;
      rebuild();
   endfunction

   function void rebuild();
      for (int i = 0; i < DUT_SLOTS; i++) begin
         occupancy[i] = '0;
         slot_link[i] = spba_pkg::LINK_W'(i + 1);
      end
      list_head = '0;
   endfunction

   function void configure(logic [spba_pkg::LINK_W-1:0] value);
      file_slots = value;
      rebuild();
   endfunction

   // slot count clamped to the array size and the 16-bit page space
   function int unsigned live_slots();
      int unsigned n;
      n = file_slots;
      if (n > DUT_SLOTS) n = DUT_SLOTS;
      if (n > spba_pkg::PAGE_LIMIT_SLOTS) n = spba_pkg::PAGE_LIMIT_SLOTS;
      return n;
   endfunction

   function int pending();
      return want_status.size();
   endfunction

   // some page that is currently in use, else any page in range (any page when the file is empty)
   function logic [spba_pkg::PAGE_W-1:0] pick_used_page();
      int unsigned count;
      int unsigned slot;
      int unsigned start;
      count = live_slots();
      if (count == 0) return spba_pkg::PAGE_W'($urandom);
      for (int t = 0; t < 8; t++) begin
         slot = $urandom_range(count - 1);
         if (occupancy[slot] != 0) begin
            start = $urandom_range(63);
            for (int k = 0; k < 64; k++) begin
               if (occupancy[slot][(start + k) % 64])
                  return spba_pkg::PAGE_W'(slot * 64 + (start + k) % 64);
            end
         end
      end
      return spba_pkg::PAGE_W'($urandom_range(count * 64 - 1));
   endfunction

   function void note_request(spba_pkg::command_type cmd,
                              logic [spba_pkg::PAGE_W-1:0] page);
      int unsigned                 count;
      logic [9:0]                  slot;
      logic [5:0]                  bit_idx;
      logic [63:0]                 w;
      spba_pkg::status_type        st;
      logic [spba_pkg::PAGE_W-1:0] granted;
      count = live_slots();
      st = spba_pkg::STAT_OK;
      granted = '0;
      if (cmd == spba_pkg::CMD_ALLOC) begin
         if (list_head >= count) begin
            st = spba_pkg::STAT_NO_FREE;
         end else begin
            slot = list_head[9:0];
            w = occupancy[slot];
            bit_idx = 0;
            while (bit_idx < 63 && w[bit_idx]) bit_idx++;
            w[bit_idx] = 1'b1;
            occupancy[slot] = w;
            granted = {slot, bit_idx};
            if (&w) list_head = slot_link[slot];   // slot now full, unlink
         end
      end else begin
         if (int'(page) >= int'(count * 64)) begin
            st = spba_pkg::STAT_OUT_OF_RANGE;
         end else begin
            slot = page[15:6];
            bit_idx = page[5:0];
            w = occupancy[slot];
            if (!w[bit_idx]) begin
               st = spba_pkg::STAT_NOT_ALLOC;
            end else begin
               if (&w) begin
                  // full slot regains a free page: push on the head
                  slot_link[slot] = list_head;
                  list_head = {1'b0, slot};
               end
               w[bit_idx] = 1'b0;
               occupancy[slot] = w;
            end
         end
      end
      want_status.push_back(st);
      want_page.push_back(granted);
   endfunction

   function void check_result(logic [1:0] status, logic [spba_pkg::PAGE_W-1:0] page);
      spba_pkg::status_type        st;
      logic [spba_pkg::PAGE_W-1:0] granted;
      if (want_status.size() == 0) begin
         $error("result word with nothing outstanding: status %0d page %0d", status, page);
         errors++;
         return;
      end
      st = want_status.pop_front();
      granted = want_page.pop_front();
      if (status !== st) begin
         $error("status: expected %0d, actual %0d", st, status);
         errors++;
      end
      if (page !== granted) begin
         $error("granted_page: expected %0d, actual %0d", granted, page);
         errors++;
      end
   endfunction
endclass

module tb_swap_page_bitmap_allocator_core;
   import spba_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_command = 1'b0;
   logic [PAGE_W-1:0]   req_page_number = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic [PAGE_W-1:0]   rsp_granted_page;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [LINK_W-1:0]   csr_slots_in_use = '0;

   int unsigned         idle_pct = 0;
   int unsigned         stall_pct = 0;
   page_alloc_scoreboard sb;

   swap_page_bitmap_allocator_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_granted_page (rsp_granted_page),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_slots_in_use (csr_slots_in_use)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_status, rsp_granted_page);
   end

   // one request word; the scoreboard is updated on the edge that takes it
   task automatic send_request(command_type cmd, logic [PAGE_W-1:0] page);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_page_number <= page;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, page);
   endtask

   task automatic write_slot_count(logic [LINK_W-1:0] value);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid        <= 1'b1;
      csr_slots_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.configure(value);
   endtask

   task automatic send_random(int unsigned alloc_pct);
      int unsigned count;
      int unsigned pick;
      logic [PAGE_W-1:0] page;
      count = sb.live_slots();
      pick = $urandom_range(99);
      page = PAGE_W'($urandom);
      if ($urandom_range(99) < alloc_pct) begin
         send_request(CMD_ALLOC, page);
      end else begin
         if (pick < 60)
            page = sb.pick_used_page();
         else if (pick < 80 && count != 0)
            page = PAGE_W'($urandom_range(count * 64 - 1));
         else if (pick < 90 && count * 64 < 65536)
            page = PAGE_W'(count * 64 + $urandom_range(3));
         send_request(CMD_FREE, page);
      end
   endtask

   initial begin
      logic [LINK_W-1:0] phase_slots [12] = '{11'd1, 11'd2047, 11'd2, 11'd0, 11'd3, 11'd1024,
                                              11'd1, 11'd1023, 11'd4, 11'd1, 11'd2, 11'd64};
      int unsigned phase_alloc [12] = '{75, 70, 65, 50, 72, 60, 55, 80, 68, 45, 75, 70};
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset slot count, reuse of lowest page, double free
      send_request(CMD_ALLOC, 16'hffff);
      send_request(CMD_ALLOC, 16'h0000);
      send_request(CMD_FREE, 16'd0);
      send_request(CMD_FREE, 16'd0);
      send_request(CMD_FREE, 16'hffff);
      send_request(CMD_ALLOC, 16'd0);
      // count above the page space is clamped
      write_slot_count(11'd2047);
      send_request(CMD_ALLOC, 16'd0);
      send_request(CMD_FREE, 16'hffff);
      // empty file: nothing to grant, every page out of range
      write_slot_count(11'd0);
      send_request(CMD_ALLOC, 16'd0);
      send_request(CMD_FREE, 16'd0);
      send_request(CMD_FREE, 16'hffff);
      // single slot: boundary page
      write_slot_count(11'd1);
      send_request(CMD_FREE, 16'd64);
      send_request(CMD_FREE, 16'd63);
      send_request(CMD_ALLOC, 16'd0);
      send_request(CMD_FREE, 16'd0);

      for (int p = 0; p < 12; p++) begin
         write_slot_count(p == 11 ? LINK_W'($urandom_range(5, 40)) : phase_slots[p]);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 46; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 26; stall_pct = 26; end
         endcase
         for (int n = 0; n < 157; n++) send_random(phase_alloc[p]);
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

### sim.f
sv/spba_pkg.sv
sv/spba_ctrl.sv
sv/spba_datapath.sv
sv/swap_page_bitmap_allocator_core.sv
bench/tb_swap_page_bitmap_allocator_core.sv
